### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// expression must always hold
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

### sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Types and codes shared by the interpolator modules.
// ----------------------------------------------------------------------------
package pli_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_RANGE   = 3'd1,
		ST_INVALID = 3'd2,
		ST_FEW     = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH,
		S_SRCH_CMP,
		S_NBL,
		S_NBL_CMP,
		S_NBH,
		S_NBH_CMP,
		S_SHF,
		S_SHF_WR,
		S_QLO,
		S_QLO_CMP,
		S_QHI,
		S_QHI_CMP,
		S_MUL,
		S_DIVS,
		S_DIVW,
		S_SUM,
		S_RESP
	} state_t;

	localparam int unsigned DATA_W = 32;

endpackage

### sv/pli_node_mem.sv
// ----------------------------------------------------------------------------
// pli_node_mem
// Node table: x and y words, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pli_node_mem import pli_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wx,
	input  logic [DATA_W-1:0] wy,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rx,
	output logic [DATA_W-1:0] ry
);

	logic [DATA_W-1:0] x_mem [DEPTH];
	logic [DATA_W-1:0] y_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rx <= x_mem[raddr];
		ry <= y_mem[raddr];
	end

endmodule

### sv/pli_divider.sv
// ----------------------------------------------------------------------------
// pli_divider
// Serial restoring divider, 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle. The dividend's upper word must be below the divisor.
// ----------------------------------------------------------------------------
module pli_divider import pli_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2*DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0]   divisor,
	output logic                done,
	output logic [DATA_W-1:0]   quotient
);

	localparam int unsigned CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              take;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = trial - {1'b0, div_q};
		take  = !diff[DATA_W];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DATA_W-1:DATA_W];
			quo_q <= dividend[DATA_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### sv/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Sorted node table with load, query and clear items on signed Q16.16 data.
// ----------------------------------------------------------------------------
// One item is worked at a time; req_stall stays high from acceptance until the
// result is placed in the output register. A clear or an unused request goes
// straight to the response. A load runs a binary search over the n held nodes,
// the neighbor spacing checks, and a read and a write per node moved up by the
// insertion, since the table memory has one read and one write port with
// registered read data. A query runs the same search, then the serial divider
// that forms (y1-y0)*(x-x0)/(x1-x0); an exact hit on a node returns its y after
// the search and one read. MAX_NODES sets the table depth.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piecewise_linear_interpolator import pli_pkg::*; #(
	parameter int unsigned MAX_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] x_value,
	input  logic [31:0] y_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [31:0] result_y,
	output logic [6:0]  node_total
);

	localparam int unsigned CW = $clog2(MAX_NODES + 1);
	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	state_t state_q, next_state;

	logic [15:0]       min_sp_q;
	req_t              req_q;
	logic [31:0]       x_q, y_q;
	logic [CW-1:0]     count_q, lo_q, hi_q, pos_q, k_q, mid_q;
	logic              flag_q;
	status_t           status_q;
	logic [31:0]       res_q;
	logic [31:0]       x0_q, y0_q;
	logic [31:0]       mag_q, num_q, den_q;
	logic              neg_q;
	logic [63:0]       prod_s1;
	logic              rsp_valid_q;
	logic [2:0]        rsp_status_q;
	logic [31:0]       rsp_res_q;
	logic [6:0]        rsp_total_q;

	logic              accept;
	logic [CW:0]       mid_sum;
	logic [CW-1:0]     mid;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [31:0]       mem_wx, mem_wy, rd_x, rd_y;
	logic [32:0]       dx, adx, dy;
	logic              near;
	logic              rd_le;
	logic              div_done;
	logic [31:0]       quo;
	logic [33:0]       sum;
	logic [31:0]       sat;
	logic [CW+6:0]     total_ext;
	logic              resp_free;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign resp_free = !rsp_valid_q || !rsp_stall;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CW:1];

	// node table
	pli_node_mem #(.DEPTH(MAX_NODES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wx    (mem_wx),
		.wy    (mem_wy),
		.raddr (mem_raddr),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	// serial divider
	pli_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVS),
		.dividend (prod_s1),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quo)
	);

	// compare and difference logic on read data
	always_comb begin
		dx    = {rd_x[31], rd_x} - {x_q[31], x_q};
		adx   = dx[32] ? (33'd0 - dx) : dx;
		near  = (adx[31:0] < {16'd0, min_sp_q});
		rd_le = ($signed(rd_x) <= $signed(x_q));
		dy    = {rd_y[31], rd_y} - {y0_q[31], y0_q};
		sum   = neg_q ? ({{2{y0_q[31]}}, y0_q} - {2'b00, quo})
			: ({{2{y0_q[31]}}, y0_q} + {2'b00, quo});
		if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
			sat = sum[31:0];
		end else if (sum[33]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7FFF_FFFF;
		end
	end

	// next state
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_LOAD:  next_state = (count_q >= CW'(MAX_NODES)) ? S_RESP : S_SRCH;
						REQ_QUERY: next_state = (flag_q || count_q < CW'(2)) ? S_RESP : S_SRCH;
						default:   next_state = S_RESP;
					endcase
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					next_state = S_SRCH_CMP;
				end else if (req_q == REQ_LOAD) begin
					next_state = S_NBL;
				end else begin
					next_state = (lo_q == '0) ? S_RESP : S_QLO;
				end
			end
			S_SRCH_CMP: next_state = S_SRCH;
			S_NBL:      next_state = (pos_q != '0) ? S_NBL_CMP : S_NBH;
			S_NBL_CMP:  next_state = S_NBH;
			S_NBH:      next_state = (pos_q < count_q) ? S_NBH_CMP : S_SHF;
			S_NBH_CMP:  next_state = S_SHF;
			S_SHF:      next_state = (k_q > pos_q) ? S_SHF_WR : S_RESP;
			S_SHF_WR:   next_state = S_SHF;
			S_QLO:      next_state = S_QLO_CMP;
			S_QLO_CMP: begin
				if (rd_x == x_q || pos_q == count_q) begin
					next_state = S_RESP;
				end else begin
					next_state = S_QHI;
				end
			end
			S_QHI:      next_state = S_QHI_CMP;
			S_QHI_CMP:  next_state = S_MUL;
			S_MUL:      next_state = S_DIVS;
			S_DIVS:     next_state = S_DIVW;
			S_DIVW:     next_state = div_done ? S_SUM : S_DIVW;
			S_SUM:      next_state = S_RESP;
			S_RESP:     next_state = resp_free ? S_IDLE : S_RESP;
			default:    next_state = S_IDLE;
		endcase
	end

	// table memory control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = k_q[AW-1:0];
		mem_wx    = rd_x;
		mem_wy    = rd_y;
		mem_raddr = pos_q[AW-1:0];
		unique case (state_q)
			S_SRCH:       mem_raddr = mid[AW-1:0];
			S_NBL, S_QLO: mem_raddr = AW'(pos_q - 1'b1);
			S_SHF: begin
				mem_raddr = AW'(k_q - 1'b1);
				if (k_q == pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wx    = x_q;
					mem_wy    = y_q;
				end
			end
			S_SHF_WR:     mem_we = 1'b1;
			default:      mem_raddr = pos_q[AW-1:0];
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sp_q <= 16'd7;
		end else if (cfg_wr_en) begin
			min_sp_q <= cfg_wr_data;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			flag_q  <= 1'b0;
		end else begin
			state_q <= next_state;
			if (state_q == S_IDLE && accept && req_type == REQ_CLEAR) begin
				count_q <= '0;
				flag_q  <= 1'b0;
			end
			if ((state_q == S_NBL_CMP || state_q == S_NBH_CMP) && near) begin
				flag_q <= 1'b1;
			end
			if (state_q == S_SHF && k_q == pos_q) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= req_t'(req_type);
				x_q      <= x_value;
				y_q      <= y_value;
				lo_q     <= '0;
				hi_q     <= count_q;
				res_q    <= '0;
				status_q <= ST_OK;
				if (req_type == REQ_LOAD && count_q >= CW'(MAX_NODES)) begin
					status_q <= ST_FULL;
				end else if (req_type == REQ_QUERY) begin
					if (flag_q) begin
						status_q <= ST_INVALID;
					end else if (count_q < CW'(2)) begin
						status_q <= ST_FEW;
					end
				end
			end
			S_SRCH: begin
				mid_q <= mid;
				pos_q <= lo_q;
				if (lo_q >= hi_q && req_q == REQ_QUERY && lo_q == '0) begin
					status_q <= ST_RANGE;
				end
			end
			S_SRCH_CMP: begin
				if (rd_le) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_NBL: k_q <= count_q;
			S_SHF: begin
				if (k_q == pos_q) begin
					status_q <= flag_q ? ST_INVALID : ST_OK;
				end
			end
			S_SHF_WR: k_q <= k_q - 1'b1;
			S_QLO: pos_q <= pos_q;
			S_QLO_CMP: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
				if (rd_x == x_q) begin
					res_q <= rd_y;
				end else if (pos_q == count_q) begin
					status_q <= ST_RANGE;
				end
			end
			S_QHI_CMP: begin
				neg_q <= dy[32];
				mag_q <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
				num_q <= x_q - x0_q;
				den_q <= rd_x - x0_q;
			end
			S_MUL: prod_s1 <= 64'(mag_q) * 64'(num_q);
			S_SUM: res_q <= sat;
			default: res_q <= res_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && resp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign total_ext = {7'd0, count_q};

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && resp_free) begin
			rsp_status_q <= status_q;
			rsp_res_q    <= (status_q == ST_OK) ? res_q : 32'd0;
			rsp_total_q  <= total_ext[6:0];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_status_q;
	assign result_y   = rsp_res_q;
	assign node_total = rsp_total_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(MAX_NODES))
	`ASSERT_IMPL(a_search_open, clk, arst_n, state_q == S_SRCH_CMP, lo_q < hi_q)
	`ASSERT_IMPL(a_div_fits, clk, arst_n, state_q == S_DIVS, prod_s1[63:32] < den_q)
	`ASSERT_IMPL(a_shift_range, clk, arst_n, state_q == S_SHF_WR, k_q > pos_q)

endmodule
